// ===== rtl/agr_pkg.sv =====
// Shared constants and types for the white-balance gain calculator.
package agr_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned NUM_W      = 25;
  localparam int unsigned DIV_STAGES = 5;
  localparam int unsigned DIV_BITS   = NUM_W / DIV_STAGES;
  localparam int unsigned ADDR_W     = 3;

  localparam logic [DATA_W-1:0] RATIO_ONE  = 16'd512;
  localparam logic [DATA_W-1:0] UNITY_GAIN = 16'h0100;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_IN    = 2'd1,
    ST_ZERO_RATIO = 2'd2
  } status_t;

  typedef enum logic {
    REG_GOLDEN_RG = 1'b0,
    REG_GOLDEN_BG = 1'b1
  } reg_idx_t;

  // Side information that travels with an item through the second division.
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] r_ratio;
    logic [DATA_W-1:0] b_ratio;
  } side_t;

endpackage

// ===== rtl/agr_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface agr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] measured_rg;
  logic [15:0] measured_bg;
  modport source (output valid, output measured_rg, output measured_bg, input ready);
  modport sink   (input valid, input measured_rg, input measured_bg, output ready);
endinterface

interface agr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_gain;
  logic [15:0] green_gain;
  logic [15:0] blue_gain;
  logic [1:0]  status;
  modport source (output valid, output red_gain, output green_gain, output blue_gain,
                  output status, input ready);
  modport sink   (input valid, input red_gain, input green_gain, input blue_gain,
                  input status, output ready);
endinterface

// ===== rtl/awb_gain_from_ratios.sv =====
// Top level of the white-balance gain calculator with its register port.
// The block takes one measured R/G, B/G ratio pair per item and returns red,
// green and blue gains (0x100 is unity) plus a status code. An item can enter
// in every cycle unless the result side stalls; each then passes through
// five stages of the divider that forms the correction ratios against the
// golden ratios, five stages of the divider bank that forms the gains, and the
// output register. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stall on the result side holds every
// item in place and in_chan.ready follows that condition. The golden ratios
// live in two APB registers (the golden R/G ratio at 0x0, the golden B/G ratio
// at 0x4, both reset to 512) and are sampled when an item is accepted. A zero
// operand gives status 1 and a correction ratio that truncates to zero gives
// status 2, with all gains zero in both cases.
module awb_gain_from_ratios (
  input  logic                        clk,
  input  logic                        rst_n,
  agr_in_if.sink                      in_chan,
  agr_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [agr_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import agr_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] typ_rg_r, typ_bg_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      typ_rg_r <= RATIO_ONE;
      typ_bg_r <= RATIO_ONE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GOLDEN_RG: typ_rg_r <= cfg_pwdata[DATA_W-1:0];
        REG_GOLDEN_BG: typ_bg_r <= cfg_pwdata[DATA_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GOLDEN_RG: cfg_prdata = {16'd0, typ_rg_r};
      REG_GOLDEN_BG: cfg_prdata = {16'd0, typ_bg_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Pipeline advance: every stage moves when the output register frees up.
  logic out_valid_r;
  logic en;
  logic accept;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;
  assign accept        = in_chan.valid && en;

  // First division: correction ratios 512 * typical / measured.
  logic              zero_in;
  logic [DATA_W-1:0] r_ratio, b_ratio;

  assign zero_in = (in_chan.measured_rg == '0) || (in_chan.measured_bg == '0) ||
                   (typ_rg_r == '0) || (typ_bg_r == '0);

  agr_div u_div_r (
    .clk(clk), .en(en),
    .num_i({typ_rg_r, 9'd0}), .den_i(in_chan.measured_rg), .quo_o(r_ratio)
  );
  agr_div u_div_b (
    .clk(clk), .en(en),
    .num_i({typ_bg_r, 9'd0}), .den_i(in_chan.measured_bg), .quo_o(b_ratio)
  );

  logic a_vld_r  [DIV_STAGES];
  logic a_zero_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) a_vld_r[i] <= 1'b0;
    end else if (en) begin
      a_vld_r[0] <= accept;
      for (int i = 1; i < DIV_STAGES; i++) a_vld_r[i] <= a_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_zero_r[0] <= zero_in;
      for (int i = 1; i < DIV_STAGES; i++) a_zero_r[i] <= a_zero_r[i-1];
    end
  end

  // Status of the item leaving the first divider. A zero ratio is replaced
  // by one as a divisor; its results are masked at the output anyway.
  side_t             side_a;
  logic [DATA_W-1:0] den_r, den_b;

  always_comb begin
    side_a.r_ratio = r_ratio;
    side_a.b_ratio = b_ratio;
    if (a_zero_r[DIV_STAGES-1]) begin
      side_a.status = ST_ZERO_IN;
    end else if ((r_ratio == '0) || (b_ratio == '0)) begin
      side_a.status = ST_ZERO_RATIO;
    end else begin
      side_a.status = ST_OK;
    end
  end

  assign den_r = (r_ratio == '0) ? 16'd1 : r_ratio;
  assign den_b = (b_ratio == '0) ? 16'd1 : b_ratio;

  // Second division: all candidate gains at once, selection at the end.
  logic [DATA_W-1:0] g_over_r, g_over_b, b_over_r, r_over_b;

  agr_div u_div_gr (
    .clk(clk), .en(en),
    .num_i(25'(32'h0002_0000)), .den_i(den_r), .quo_o(g_over_r)
  );
  agr_div u_div_gb (
    .clk(clk), .en(en),
    .num_i(25'(32'h0002_0000)), .den_i(den_b), .quo_o(g_over_b)
  );
  agr_div u_div_br (
    .clk(clk), .en(en),
    .num_i({1'b0, b_ratio, 8'd0}), .den_i(den_r), .quo_o(b_over_r)
  );
  agr_div u_div_rb (
    .clk(clk), .en(en),
    .num_i({1'b0, r_ratio, 8'd0}), .den_i(den_b), .quo_o(r_over_b)
  );

  logic  b_vld_r  [DIV_STAGES];
  side_t b_side_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) b_vld_r[i] <= 1'b0;
    end else if (en) begin
      b_vld_r[0] <= a_vld_r[DIV_STAGES-1];
      for (int i = 1; i < DIV_STAGES; i++) b_vld_r[i] <= b_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r[0] <= side_a;
      for (int i = 1; i < DIV_STAGES; i++) b_side_r[i] <= b_side_r[i-1];
    end
  end

  // Gain selection: the channel whose ratio needs the least boost stays at
  // unity; when both ratios are below one the larger green gain wins.
  side_t             side_b;
  logic              r_ge, b_ge;
  logic [DATA_W-1:0] red_nxt, green_nxt, blue_nxt;

  assign side_b = b_side_r[DIV_STAGES-1];
  assign r_ge   = side_b.r_ratio >= RATIO_ONE;
  assign b_ge   = side_b.b_ratio >= RATIO_ONE;

  always_comb begin
    red_nxt   = UNITY_GAIN;
    green_nxt = UNITY_GAIN;
    blue_nxt  = UNITY_GAIN;
    if (side_b.status != ST_OK) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else if (r_ge && b_ge) begin
      red_nxt  = side_b.r_ratio >> 1;
      blue_nxt = side_b.b_ratio >> 1;
    end else if (r_ge) begin
      red_nxt   = r_over_b;
      green_nxt = g_over_b;
    end else if (b_ge) begin
      green_nxt = g_over_r;
      blue_nxt  = b_over_r;
    end else if (g_over_r >= g_over_b) begin
      green_nxt = g_over_r;
      blue_nxt  = b_over_r;
    end else begin
      red_nxt   = r_over_b;
      green_nxt = g_over_b;
    end
  end

  // Output register.
  logic [DATA_W-1:0] red_r, green_r, blue_r;
  status_t           status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
      status_r <= side_b.status;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.red_gain   = red_r;
  assign out_chan.green_gain = green_r;
  assign out_chan.blue_gain  = blue_r;
  assign out_chan.status     = status_r;

  // An error result carries no gains.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |->
      (red_r == '0) && (green_r == '0) && (blue_r == '0))
    else $error("error result with nonzero gain");

  // A good result always keeps one channel at unity.
  a_unity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_OK) |->
      (red_r == UNITY_GAIN) || (green_r == UNITY_GAIN) || (blue_r == UNITY_GAIN))
    else $error("no channel at unity gain");

  // An accepted zero operand enters the pipeline with its zero flag set.
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept && zero_in |=> a_vld_r[0] && a_zero_r[0])
    else $error("zero operand lost in pipeline");

  // A held result stays put while the sink stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(red_r) && $stable(status_r))
    else $error("stalled result changed");

endmodule

// ===== rtl/agr_div.sv =====
// Pipelined restoring divider, several quotient bits per register stage.
module agr_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [agr_pkg::NUM_W-1:0]   num_i,
  input  logic [agr_pkg::DATA_W-1:0]  den_i,
  output logic [agr_pkg::DATA_W-1:0]  quo_o
);
  import agr_pkg::*;

  // Each stage holds the partial remainder and a word whose top holds the
  // numerator bits still to consume and whose bottom collects quotient bits.
  logic [DATA_W-1:0] rem_r [DIV_STAGES];
  logic [NUM_W-1:0]  nq_r  [DIV_STAGES];
  logic [DATA_W-1:0] den_r [DIV_STAGES];

  genvar s;
  for (s = 0; s < DIV_STAGES; s++) begin : g_st
    logic [DATA_W-1:0] rem_in, den_in, rem_nxt;
    logic [NUM_W-1:0]  nq_in, nq_nxt;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign nq_in  = nq_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin : c_step
      logic [DATA_W:0] t;
      rem_nxt = rem_in;
      nq_nxt  = nq_in;
      for (int i = 0; i < DIV_BITS; i++) begin
        t = {rem_nxt, nq_nxt[NUM_W-1]};
        if (t >= {1'b0, den_in}) begin
          t      = t - {1'b0, den_in};
          nq_nxt = {nq_nxt[NUM_W-2:0], 1'b1};
        end else begin
          nq_nxt = {nq_nxt[NUM_W-2:0], 1'b0};
        end
        rem_nxt = t[DATA_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        nq_r[s]  <= nq_nxt;
        den_r[s] <= den_in;
      end
    end
  end

  assign quo_o = nq_r[DIV_STAGES-1][DATA_W-1:0];

endmodule
